[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the glob sequence matcher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("glob match check failed");

// Next-cycle implication, checked only outside reset.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("glob match check failed");

`endif

[src/gcsm_pkg.sv]
// ----------------------------------------------------------------------------
// gcsm_pkg
// Types and constants shared by the glob sequence matcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gcsm_pkg;

    localparam int MAX_TOKENS_DEF   = 16;
    localparam int MAX_CHANNELS_DEF = 8;

    // Tokens covered by the kind and mask registers, and the padded count
    // that covers the largest token parameter.
    localparam int REG_TOKENS  = 16;
    localparam int PAD_TOKENS  = 32;
    localparam int MASK_W      = 8;

    localparam int COUNT_W     = 5;
    localparam int KINDS_W     = 32;
    localparam int MASKS_W     = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CHANNEL_W   = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TOKEN_COUNT = 2'd0,
        REG_TOKEN_KINDS = 2'd1,
        REG_MASKS_LOW   = 2'd2,
        REG_MASKS_HIGH  = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_LETTER = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_MULTI  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [COUNT_W-1:0] token_count;
        logic [KINDS_W-1:0] token_kinds;
        logic [MASKS_W-1:0] masks_low;
        logic [MASKS_W-1:0] masks_high;
    } cfg_t;

endpackage

`default_nettype wire

[src/gcsm_step.sv]
// ----------------------------------------------------------------------------
// gcsm_step
// One layer of the bit-parallel glob match: closes the live position set,
// advances it by one channel and closes the result again.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsm_step #(
    parameter int MAX_TOKENS   = gcsm_pkg::MAX_TOKENS_DEF,
    parameter int MAX_CHANNELS = gcsm_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic [MAX_TOKENS:0]           live,
    input  wire logic [gcsm_pkg::CHANNEL_W-1:0] channel,
    input  wire gcsm_pkg::cfg_t                cfg,
    output logic      [MAX_TOKENS:0]           live_next,
    output logic                               matched
);

    localparam int W      = MAX_TOKENS + 1;
    localparam int LEVELS = (W > 1) ? $clog2(W) : 1;
    localparam int CH_LIM = (MAX_CHANNELS < gcsm_pkg::MASK_W) ? MAX_CHANNELS
                                                               : gcsm_pkg::MASK_W;
    localparam logic [gcsm_pkg::CHANNEL_W-1:0] CH_LIMIT = gcsm_pkg::CHANNEL_W'(CH_LIM);

    logic [2*gcsm_pkg::PAD_TOKENS-1:0]                 kinds_all;
    logic [gcsm_pkg::MASK_W*gcsm_pkg::PAD_TOKENS-1:0]  masks_all;
    logic [W-1:0] active;
    logic [W-1:0] multi;
    logic [W-1:0] end_pos;
    logic [W-1:0] cur;
    logic [W-1:0] advanced;
    logic         chan_ok;

    // A live position in front of an active multi wildcard also makes the
    // following position live. The chain is resolved as a parallel prefix.
    function automatic logic [W-1:0] close_set(input logic [W-1:0] s,
                                               input logic [W-1:0] p_in);
        logic [W-1:0] g;
        logic [W-1:0] p;
        logic [W-1:0] g_n;
        logic [W-1:0] p_n;
        g = s;
        p = p_in;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            g_n = g;
            p_n = '0;
            for (int j = 0; j < W; j++) begin
                if (j >= (1 << lvl))
                    g_n[j] = g[j] | (g[j - (1 << lvl)] & p[j - (1 << lvl)]);
                if (j + (1 << lvl) < W)
                    p_n[j] = p[j] & p[j + (1 << lvl)];
            end
            g = g_n;
            p = p_n;
        end
        return g;
    endfunction

    // Tokens beyond the registers never match anything.
    assign kinds_all = {{(2*gcsm_pkg::PAD_TOKENS-gcsm_pkg::KINDS_W){1'b1}}, cfg.token_kinds};
    assign masks_all = {{(gcsm_pkg::MASK_W*gcsm_pkg::PAD_TOKENS-2*gcsm_pkg::MASKS_W){1'b0}},
                        cfg.masks_high, cfg.masks_low};
    assign chan_ok   = (channel < CH_LIMIT);

    always_comb
    begin
        active = '0;
        multi  = '0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            active[i] = (i < int'(cfg.token_count));
            multi[i]  = active[i] &&
                        (gcsm_pkg::kind_t'(kinds_all[2*i +: 2]) == gcsm_pkg::KIND_MULTI);
        end
        end_pos = '0;
        for (int i = 1; i < W; i++)
            end_pos[i] = active[i-1] & ~active[i];
    end

    assign cur = close_set(live, multi);

    always_comb
    begin
        advanced = '0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            if (cur[i] && active[i]) begin
                case (gcsm_pkg::kind_t'(kinds_all[2*i +: 2]))
                    gcsm_pkg::KIND_LETTER:
                    begin
                        if (chan_ok && masks_all[gcsm_pkg::MASK_W*i + int'(channel[2:0])])
                            advanced[i+1] = 1'b1;
                    end
                    gcsm_pkg::KIND_SINGLE: advanced[i+1] = 1'b1;
                    gcsm_pkg::KIND_MULTI:  advanced[i]   = 1'b1;
                    default: ;
                endcase
            end
        end
    end

    assign live_next = close_set(advanced, multi);
    assign matched   = |(live_next & end_pos);

endmodule

`default_nettype wire

[src/glob_class_sequence_match.sv]
// A last layer is held in the s1 register, then its step result is registered on out_valid.
// Throughput: one layer per cycle while in_stall is low; the live-set update through one register stage sets it.
// A stalled result holds only a layer flagged last; other layers keep flowing.
// Reset clears the valid flags and the pattern (no match) and sets the live set to the start position.
// ----------------------------------------------------------------------------
// glob_class_sequence_match
// Matches a stream of channel indices against a configured glob pattern.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module glob_class_sequence_match #(
    parameter int MAX_TOKENS   = gcsm_pkg::MAX_TOKENS_DEF,
    parameter int MAX_CHANNELS = gcsm_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [gcsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [gcsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [gcsm_pkg::CHANNEL_W-1:0]   channel,
    input  wire logic                             last_layer,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  matched
);

    localparam logic [MAX_TOKENS:0] START = {{MAX_TOKENS{1'b0}}, 1'b1};

    gcsm_pkg::cfg_t cfg_reg;
    gcsm_pkg::cfg_t cfg_next;

    logic [MAX_TOKENS:0]            live_reg;
    logic [MAX_TOKENS:0]            live_next;
    logic [MAX_TOKENS:0]            step_live;
    logic                           step_matched;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [gcsm_pkg::CHANNEL_W-1:0] s1_channel_reg;
    logic                           s1_last_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           matched_reg;

    logic                           in_accept;
    logic                           out_free;
    logic                           s1_fire;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en) begin
            case (gcsm_pkg::reg_index_t'(cfg_index))
                gcsm_pkg::REG_TOKEN_COUNT:
                    cfg_next.token_count = cfg_data[gcsm_pkg::COUNT_W-1:0];
                gcsm_pkg::REG_TOKEN_KINDS:
                    cfg_next.token_kinds = cfg_data[gcsm_pkg::KINDS_W-1:0];
                gcsm_pkg::REG_MASKS_LOW:
                    cfg_next.masks_low   = cfg_data[gcsm_pkg::MASKS_W-1:0];
                gcsm_pkg::REG_MASKS_HIGH:
                    cfg_next.masks_high  = cfg_data[gcsm_pkg::MASKS_W-1:0];
                default: ;
            endcase
        end
    end

    gcsm_step #(
        .MAX_TOKENS   (MAX_TOKENS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_step (
        .live      (live_reg),
        .channel   (s1_channel_reg),
        .cfg       (cfg_reg),
        .live_next (step_live),
        .matched   (step_matched)
    );

    // Only a last layer needs room in the result register.
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign s1_fire   = s1_valid_reg & (~s1_last_reg | out_free);
    assign in_stall  = s1_valid_reg & ~s1_fire;
    assign in_accept = in_valid & ~in_stall;

    assign s1_valid_next  = in_accept | (s1_valid_reg & ~s1_fire);
    assign out_valid_next = (s1_fire & s1_last_reg) | (out_valid_reg & out_stall);

    always_comb
    begin
        live_next = live_reg;
        if (s1_fire)
            live_next = s1_last_reg ? START : step_live;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg       <= '0;
            live_reg      <= START;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            live_reg      <= live_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            s1_channel_reg <= channel;
            s1_last_reg    <= last_layer;
        end
        if (s1_fire && s1_last_reg)
            matched_reg <= step_matched;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

    `ASSERT_IMPL(a_stall_only_when_held, clk, rst_n, in_stall, s1_valid_reg && s1_last_reg)
    `ASSERT_NEXT(a_restart_after_last, clk, rst_n, s1_fire && s1_last_reg, live_reg == START)
    `ASSERT_IMPL(a_result_from_last, clk, rst_n, $rose(out_valid_reg), $past(s1_fire && s1_last_reg))

endmodule

`default_nettype wire
